@@ hdl/quadratic_form_engine_macros.svh @@
// Assertion macros for the quadratic form engine
`ifndef QUADRATIC_FORM_ENGINE_MACROS_SVH
`define QUADRATIC_FORM_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define QFE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qfe check failed");
`define QFE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qfe check failed");
`else
`define QFE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define QFE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/qfe_pkg.sv @@
// Types, codes and helpers shared by the quadratic form engine
package qfe_pkg;

  typedef enum logic [2:0] {
    K_WR_A  = 3'd0,
    K_WR_B  = 3'd1,
    K_WR_C  = 3'd2,
    K_X     = 3'd3,
    K_T     = 3'd4,
    K_CLR   = 3'd5,
    K_SCALE = 3'd6
  } kind_t;

  localparam logic [1:0] DONE_EVAL  = 2'd0;
  localparam logic [1:0] DONE_TRANS = 2'd1;
  localparam logic [1:0] DONE_SCALE = 2'd2;

  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  typedef struct packed {
    logic [2:0]          kind;
    logic [2:0]          row;
    logic [2:0]          col;
    logic signed [31:0]  value;
    logic                last;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0]  result_value;
    logic                overflow;
    logic [1:0]          op_done;
  } result_t;

  typedef struct packed {
    logic eval;
    logic trans;
    logic scale;
  } seq_go_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] value;
  } sat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_E_RD, S_E_MUL, S_E_ACC, S_E_SAT, S_E_XS, S_E_ACC1, S_E_ACC2, S_E_FIN,
    S_T_CM, S_T_CW, S_T_RD, S_T_M1, S_T_W1, S_T_W2, S_T_M3, S_T_W3,
    S_S_RD, S_S_M, S_S_W, S_S_BM, S_S_BW, S_S_CM, S_S_CW,
    S_DONE
  } st_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    r.ovf = !((&v[63:31]) || !(|v[63:31]));
    if (!r.ovf) begin
      r.value = v[31:0];
    end else if (v[63]) begin
      r.value = 32'sh8000_0000;
    end else begin
      r.value = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

@@ hdl/qfe_ram.sv @@
// Generic single write port RAM with registered read
module qfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/qfe_mul.sv @@
// Shared signed multiplier with product register and Q16.16 truncation
module qfe_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [47:0] tr
);

  logic signed [63:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 64'(a) * 64'(b);
    end
  end

  // drop 16 fraction bits: floor toward minus infinity
  assign tr = prod[63:16];

endmodule

@@ hdl/qfe_seq.sv @@
// Sequencer: state and loop counters for evaluation, translation, scaling
module qfe_seq #(
  parameter int NUM_VARS = 8,
  localparam int IDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  qfe_pkg::seq_go_t    go,
  input  logic [IDX_W-1:0]    n_m1,
  input  logic                out_free,
  output qfe_pkg::st_t        st,
  output logic [IDX_W-1:0]    i,
  output logic [IDX_W-1:0]    j
);

  localparam logic [IDX_W-1:0] NV_M1 = IDX_W'(NUM_VARS - 1);
  localparam logic [IDX_W-1:0] ONE   = IDX_W'(1);

  qfe_pkg::st_t     st_next;
  logic [IDX_W-1:0] i_next;
  logic [IDX_W-1:0] j_next;

  always_comb begin
    st_next = st;
    case (st)
      qfe_pkg::S_IDLE: begin
        if (go.eval) begin
          st_next = qfe_pkg::S_E_RD;
        end else if (go.trans) begin
          st_next = qfe_pkg::S_T_CM;
        end else if (go.scale) begin
          st_next = qfe_pkg::S_S_RD;
        end
      end
      qfe_pkg::S_E_RD:   st_next = qfe_pkg::S_E_MUL;
      qfe_pkg::S_E_MUL:  st_next = qfe_pkg::S_E_ACC;
      qfe_pkg::S_E_ACC:  st_next = (j == n_m1) ? qfe_pkg::S_E_SAT : qfe_pkg::S_E_RD;
      qfe_pkg::S_E_SAT:  st_next = qfe_pkg::S_E_XS;
      qfe_pkg::S_E_XS:   st_next = qfe_pkg::S_E_ACC1;
      qfe_pkg::S_E_ACC1: st_next = qfe_pkg::S_E_ACC2;
      qfe_pkg::S_E_ACC2: st_next = (i == n_m1) ? qfe_pkg::S_E_FIN : qfe_pkg::S_E_RD;
      qfe_pkg::S_E_FIN:  st_next = qfe_pkg::S_DONE;
      qfe_pkg::S_T_CM:   st_next = qfe_pkg::S_T_CW;
      qfe_pkg::S_T_CW:   st_next = (i == n_m1) ? qfe_pkg::S_T_RD : qfe_pkg::S_T_CM;
      qfe_pkg::S_T_RD:   st_next = qfe_pkg::S_T_M1;
      qfe_pkg::S_T_M1:   st_next = qfe_pkg::S_T_W1;
      qfe_pkg::S_T_W1:   st_next = qfe_pkg::S_T_W2;
      qfe_pkg::S_T_W2:   st_next = qfe_pkg::S_T_M3;
      qfe_pkg::S_T_M3:   st_next = qfe_pkg::S_T_W3;
      qfe_pkg::S_T_W3: begin
        st_next = (i == n_m1 && j == n_m1) ? qfe_pkg::S_DONE : qfe_pkg::S_T_RD;
      end
      qfe_pkg::S_S_RD:   st_next = qfe_pkg::S_S_M;
      qfe_pkg::S_S_M:    st_next = qfe_pkg::S_S_W;
      qfe_pkg::S_S_W: begin
        st_next = (i == NV_M1 && j == NV_M1) ? qfe_pkg::S_S_BM : qfe_pkg::S_S_RD;
      end
      qfe_pkg::S_S_BM:   st_next = qfe_pkg::S_S_BW;
      qfe_pkg::S_S_BW:   st_next = (i == NV_M1) ? qfe_pkg::S_S_CM : qfe_pkg::S_S_BM;
      qfe_pkg::S_S_CM:   st_next = qfe_pkg::S_S_CW;
      qfe_pkg::S_S_CW:   st_next = qfe_pkg::S_DONE;
      qfe_pkg::S_DONE:   st_next = out_free ? qfe_pkg::S_IDLE : qfe_pkg::S_DONE;
      default:           st_next = qfe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    i_next = i;
    j_next = j;
    case (st)
      qfe_pkg::S_IDLE: begin
        i_next = '0;
        j_next = '0;
      end
      qfe_pkg::S_E_ACC: begin
        j_next = (j == n_m1) ? '0 : j + ONE;
      end
      qfe_pkg::S_E_ACC2: begin
        i_next = i + ONE;
      end
      qfe_pkg::S_T_CW: begin
        i_next = (i == n_m1) ? '0 : i + ONE;
      end
      qfe_pkg::S_T_W3: begin
        if (j == n_m1) begin
          j_next = '0;
          i_next = i + ONE;
        end else begin
          j_next = j + ONE;
        end
      end
      qfe_pkg::S_S_W: begin
        if (j == NV_M1) begin
          j_next = '0;
          i_next = (i == NV_M1) ? '0 : i + ONE;
        end else begin
          j_next = j + ONE;
        end
      end
      qfe_pkg::S_S_BW: begin
        i_next = i + ONE;
      end
      default: begin
        i_next = i;
        j_next = j;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= qfe_pkg::S_IDLE;
      i  <= '0;
      j  <= '0;
    end else begin
      st <= st_next;
      i  <= i_next;
      j  <= j_next;
    end
  end

endmodule

@@ hdl/quadratic_form_engine.sv @@
// Quadratic form engine top level: f(x) = x'Ax + b'x + c in Q16.16, one shared multiplier.
// Evaluation and translation run over n = active variables, scaling over all NUM_VARS;
// at most one multiply per step; commands are accepted only while idle.
// Coefficient writes, clear and non-last elements need no sequence; one item at a time.
// Reset (rst, synchronous) zeroes A via per-entry valid bits and b, c directly; active_vars = 8.
`include "quadratic_form_engine_macros.svh"
module quadratic_form_engine #(
  parameter int NUM_VARS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  input  qfe_pkg::cmd_t     cmd,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  output qfe_pkg::result_t  result,
  output logic              result_valid,
  input  logic              result_stall
);

  localparam int IDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int AW    = 2 * IDX_W;
  localparam int RAM_D = 1 << AW;
  localparam int ROW_W = 48 + IDX_W;
  localparam int ACC_W = 51 + IDX_W;

  qfe_pkg::st_t        st;
  qfe_pkg::seq_go_t    go;
  qfe_pkg::sat_t       sat_o;
  qfe_pkg::sat_t       sat_tr;
  logic [IDX_W-1:0]    i;
  logic [IDX_W-1:0]    j;
  logic [IDX_W-1:0]    n_m1;
  logic [IDX_W-1:0]    row_idx;
  logic [IDX_W-1:0]    col_idx;
  logic [IDX_W-1:0]    x_idx;
  logic [IDX_W-1:0]    b_idx;
  logic [3:0]          active_vars;
  logic                accept;
  logic                out_free;
  logic                row_ok;
  logic                col_ok;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_wdata;
  logic [31:0]         ram_rdata;
  logic [RAM_D-1:0]    a_vld;
  logic                a_vld_rd;
  logic signed [31:0]  x_q [NUM_VARS];
  logic signed [31:0]  b_q [NUM_VARS];
  logic signed [31:0]  c_q;
  logic signed [31:0]  a_q;
  logic signed [31:0]  at_q;
  logic signed [31:0]  s_q;
  logic signed [31:0]  scale_q;
  logic signed [31:0]  res_q;
  logic signed [ROW_W-1:0] row_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                ovf_q;
  logic [1:0]          done_q;
  logic signed [31:0]  x_rd;
  logic signed [31:0]  b_rd;
  logic signed [31:0]  a_rd;
  logic signed [31:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic                mul_en;
  logic signed [47:0]  tr;
  logic signed [31:0]  addend;
  logic signed [63:0]  sat_in;
  logic                sat_use;

  assign cmd_stall = (st != qfe_pkg::S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !result_valid || !result_stall;

  assign row_ok  = (32'(cmd.row) < NUM_VARS);
  assign col_ok  = (32'(cmd.col) < NUM_VARS);
  assign row_idx = IDX_W'(cmd.row);
  assign col_idx = IDX_W'(cmd.col);

  assign go.eval  = accept && cmd.kind == qfe_pkg::K_X && cmd.last;
  assign go.trans = accept && cmd.kind == qfe_pkg::K_T && cmd.last;
  assign go.scale = accept && cmd.kind == qfe_pkg::K_SCALE;

  always_comb begin
    if (active_vars == 4'd0) begin
      n_m1 = '0;
    end else if (32'(active_vars) > NUM_VARS) begin
      n_m1 = IDX_W'(NUM_VARS - 1);
    end else begin
      n_m1 = IDX_W'(active_vars - 4'd1);
    end
  end

  qfe_seq #(.NUM_VARS(NUM_VARS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .n_m1     (n_m1),
    .out_free (out_free),
    .st       (st),
    .i        (i),
    .j        (j)
  );

  assign ram_we    = (accept && cmd.kind == qfe_pkg::K_WR_A && row_ok && col_ok)
                     || st == qfe_pkg::S_S_W;
  assign ram_waddr = (st == qfe_pkg::S_S_W) ? {i, j} : {row_idx, col_idx};
  assign ram_wdata = (st == qfe_pkg::S_S_W) ? sat_tr.value : cmd.value;

  qfe_ram #(.WIDTH(32), .DEPTH(RAM_D)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr ({i, j}),
    .rdata (ram_rdata)
  );

  assign a_rd = a_vld_rd ? ram_rdata : 32'sd0;

  always_comb begin
    x_idx = i;
    b_idx = i;
    case (st)
      qfe_pkg::S_E_MUL, qfe_pkg::S_T_M1, qfe_pkg::S_T_M3: x_idx = j;
      default: x_idx = i;
    endcase
    if (st == qfe_pkg::S_T_W2) begin
      b_idx = j;
    end
  end

  assign x_rd = x_q[x_idx];
  assign b_rd = b_q[b_idx];

  always_comb begin
    mul_en = 1'b1;
    mul_a  = a_rd;
    mul_b  = x_rd;
    case (st)
      qfe_pkg::S_E_MUL, qfe_pkg::S_T_M1: begin
        mul_a = a_rd;
        mul_b = x_rd;
      end
      qfe_pkg::S_E_XS: begin
        mul_a = x_rd;
        mul_b = s_q;
      end
      qfe_pkg::S_E_ACC1, qfe_pkg::S_T_CM: begin
        mul_a = b_rd;
        mul_b = x_rd;
      end
      qfe_pkg::S_T_W1: begin
        mul_a = a_q;
        mul_b = x_rd;
      end
      qfe_pkg::S_T_M3: begin
        mul_a = at_q;
        mul_b = x_rd;
      end
      qfe_pkg::S_S_M: begin
        mul_a = a_rd;
        mul_b = scale_q;
      end
      qfe_pkg::S_S_BM: begin
        mul_a = b_rd;
        mul_b = scale_q;
      end
      qfe_pkg::S_S_CM: begin
        mul_a = c_q;
        mul_b = scale_q;
      end
      default: mul_en = 1'b0;
    endcase
  end

  qfe_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .tr  (tr)
  );

  always_comb begin
    addend  = 32'sd0;
    sat_use = 1'b1;
    case (st)
      qfe_pkg::S_T_CW, qfe_pkg::S_T_W3: addend = c_q;
      qfe_pkg::S_T_W1, qfe_pkg::S_T_W2: addend = b_rd;
      qfe_pkg::S_E_SAT, qfe_pkg::S_E_FIN, qfe_pkg::S_S_W,
      qfe_pkg::S_S_BW, qfe_pkg::S_S_CW: addend = 32'sd0;
      default: sat_use = 1'b0;
    endcase
    case (st)
      qfe_pkg::S_E_SAT: sat_in = 64'(row_q);
      qfe_pkg::S_E_FIN: sat_in = 64'(acc_q);
      default:          sat_in = 64'(addend) + 64'(tr);
    endcase
  end

  assign sat_o  = qfe_pkg::sat32(sat_in);
  assign sat_tr = qfe_pkg::sat32(64'(tr));

  // coefficient and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_vars  <= qfe_pkg::ACTIVE_RESET;
      a_vld        <= '0;
      c_q          <= 32'sd0;
      ovf_q        <= 1'b0;
      result_valid <= 1'b0;
      for (int k = 0; k < NUM_VARS; k++) begin
        b_q[k] <= 32'sd0;
      end
    end else begin
      if (cfg_we) begin
        active_vars <= cfg_data;
      end
      if (ram_we) begin
        a_vld[ram_waddr] <= 1'b1;
      end
      if (accept) begin
        case (cmd.kind)
          qfe_pkg::K_WR_B: begin
            if (row_ok) begin
              b_q[row_idx] <= cmd.value;
            end
          end
          qfe_pkg::K_WR_C: c_q <= cmd.value;
          qfe_pkg::K_CLR: begin
            a_vld <= '0;
            c_q   <= 32'sd0;
            for (int k = 0; k < NUM_VARS; k++) begin
              b_q[k] <= 32'sd0;
            end
          end
          default: ;
        endcase
      end
      if (go.eval || go.trans || go.scale) begin
        ovf_q <= 1'b0;
      end else if (sat_use && sat_o.ovf) begin
        ovf_q <= 1'b1;
      end else if (st == qfe_pkg::S_T_W2 && sat_tr.ovf) begin
        ovf_q <= 1'b1;
      end
      case (st)
        qfe_pkg::S_T_CW, qfe_pkg::S_T_W3, qfe_pkg::S_S_CW: c_q <= sat_o.value;
        qfe_pkg::S_T_W1, qfe_pkg::S_T_W2, qfe_pkg::S_S_BW: b_q[b_idx] <= sat_o.value;
        default: ;
      endcase
      if (st == qfe_pkg::S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // operands and working registers
  always_ff @(posedge clk) begin
    a_vld_rd <= a_vld[{i, j}];
    if (accept && (cmd.kind == qfe_pkg::K_X || cmd.kind == qfe_pkg::K_T) && row_ok) begin
      x_q[row_idx] <= cmd.value;
    end
    if (go.eval) begin
      acc_q  <= ACC_W'(c_q);
      row_q  <= '0;
      res_q  <= 32'sd0;
      done_q <= qfe_pkg::DONE_EVAL;
    end
    if (go.trans) begin
      res_q  <= 32'sd0;
      done_q <= qfe_pkg::DONE_TRANS;
    end
    if (go.scale) begin
      res_q   <= 32'sd0;
      scale_q <= cmd.value;
      done_q  <= qfe_pkg::DONE_SCALE;
    end
    case (st)
      qfe_pkg::S_E_ACC:  row_q <= row_q + ROW_W'(tr);
      qfe_pkg::S_E_SAT:  s_q   <= sat_o.value;
      qfe_pkg::S_E_ACC1: acc_q <= acc_q + ACC_W'(tr);
      qfe_pkg::S_E_ACC2: begin
        acc_q <= acc_q + ACC_W'(tr);
        row_q <= '0;
      end
      qfe_pkg::S_E_FIN:  res_q <= sat_o.value;
      qfe_pkg::S_T_M1:   a_q   <= a_rd;
      qfe_pkg::S_T_W2:   at_q  <= sat_tr.value;
      default: ;
    endcase
    if (st == qfe_pkg::S_DONE && out_free) begin
      result.result_value <= res_q;
      result.overflow     <= ovf_q;
      result.op_done      <= done_q;
    end
  end

  `QFE_ASSERT_IMP(a_result_from_done, clk, rst, $rose(result_valid), $past(st) == qfe_pkg::S_DONE)
  `QFE_ASSERT_IMP(a_zero_unless_eval, clk, rst, result_valid && result.op_done != qfe_pkg::DONE_EVAL, result.result_value == 32'sd0)
  `QFE_ASSERT_IMP(a_index_range, clk, rst, st != qfe_pkg::S_IDLE, (32'(i) < NUM_VARS) && (32'(j) < NUM_VARS))
  `QFE_ASSERT_NXT(a_ovf_clear_on_start, clk, rst, go.eval || go.trans || go.scale, !ovf_q)

endmodule
